@@ hdl/ppft_pkg.sv @@
`default_nettype none

package ppft_pkg;

	// Table depth default
	localparam int CAPACITY_DEF = 16;

	// Field widths
	localparam int CORE_W      = 20;
	localparam int HOP_W       = 8;
	localparam int COUNT_W     = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 8;

	// Item kinds carried on the input tuser
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted beat
		logic eval;    // compare against every stored entry
		logic commit;  // update the table and load the result register
	} cmd_t;

endpackage

`default_nettype wire

@@ hdl/pareto_pair_frontier_table_top.sv @@
`default_nettype none

// Channel  Dir  tdata                                      tuser
// s_axis   in   [19:0] core_value, [27:20] hop_value       [0] mode
// m_axis   out  [0] covered, [1] overflow, [6:2] entry_count  -
//
// Each item passes a compare state, which checks it against every entry, and
// an update state, which updates the table and loads the result register.
// A new beat is taken when idle or in the update cycle in which the item commits.
// The result register holds one finished beat; the update stalls only while
// that beat is still waiting on m_axis_tready.
// arst_n clears all valid bits and the count; no clearing pass is needed.

module pareto_pair_frontier_table_top #(
	parameter int CAPACITY = ppft_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [19:0] core_value, [27:20] hop_value, [31:28] zero
	input  wire logic [ppft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [0] mode
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [0] covered, [1] overflow, [6:2] entry_count, [7] zero
	output logic [ppft_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

	ppft_pkg::cmd_t                 cmd;
	logic                           res_covered;
	logic                           res_overflow;
	logic [ppft_pkg::COUNT_W-1:0]   res_count;

	ppft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ppft_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_mode      (s_axis_tuser),
		.in_core      (s_axis_tdata[ppft_pkg::CORE_W-1:0]),
		.in_hop       (s_axis_tdata[ppft_pkg::CORE_W +: ppft_pkg::HOP_W]),
		.res_covered  (res_covered),
		.res_overflow (res_overflow),
		.res_count    (res_count)
	);

	// Output beat packing
	assign m_axis_tdata = {1'b0, res_count, res_overflow, res_covered};

endmodule

`default_nettype wire

@@ hdl/ppft_ctrl.sv @@
`default_nettype none

module ppft_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output ppft_pkg::cmd_t   cmd
);

	ppft_pkg::state_t state_q;
	ppft_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             commit;

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppft_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= commit | (out_valid_q & ~out_ready);
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		commit     = (state_q == ppft_pkg::ST_UPD) && (!out_valid_q || out_ready);
		in_ready   = (state_q == ppft_pkg::ST_IDLE) || commit;
		cmd.load   = in_valid & in_ready;
		cmd.eval   = (state_q == ppft_pkg::ST_CMP);
		cmd.commit = commit;
		case (state_q)
			ppft_pkg::ST_IDLE: begin
				if (cmd.load)
					state_nxt = ppft_pkg::ST_CMP;
			end
			ppft_pkg::ST_CMP: begin
				state_nxt = ppft_pkg::ST_UPD;
			end
			ppft_pkg::ST_UPD: begin
				if (commit)
					state_nxt = cmd.load ? ppft_pkg::ST_CMP : ppft_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ppft_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// A compare cycle is always followed by an update cycle
	a_cmp_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppft_pkg::ST_CMP) |=> (state_q == ppft_pkg::ST_UPD))
		else $error("compare not followed by update");

	// New beats only taken when idle or when the current item retires
	a_ready_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((state_q == ppft_pkg::ST_IDLE) || commit))
		else $error("input ready while an item is in flight");

	// A result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

@@ hdl/ppft_dp.sv @@
`default_nettype none

module ppft_dp #(
	parameter int CAPACITY = ppft_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ppft_pkg::cmd_t                cmd,
	input  wire logic                          in_mode,
	input  wire logic [ppft_pkg::CORE_W-1:0]   in_core,
	input  wire logic [ppft_pkg::HOP_W-1:0]    in_hop,
	output logic                               res_covered,
	output logic                               res_overflow,
	output logic [ppft_pkg::COUNT_W-1:0]       res_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Captured item
	logic                        mode_q;
	logic [ppft_pkg::CORE_W-1:0] core_q;
	logic [ppft_pkg::HOP_W-1:0]  hop_q;

	// Entry table
	logic [CAPACITY-1:0]         valid_q;
	logic [ppft_pkg::CORE_W-1:0] tab_core_q [CAPACITY];
	logic [ppft_pkg::HOP_W-1:0]  tab_hop_q  [CAPACITY];
	logic [CNT_W-1:0]            count_q;

	// Compare stage
	logic [CAPACITY-1:0] kill_c;
	logic [CAPACITY-1:0] match_c;
	logic [CAPACITY-1:0] cover_c;
	logic                ins_ok;
	logic [CAPACITY-1:0] kill_s1;
	logic                present_s1;
	logic                cover_s1;
	logic                ins_s1;
	logic                query_s1;

	// Update stage
	logic [CAPACITY-1:0] nv;
	logic [CAPACITY-1:0] free_oh;
	logic                full;
	logic                do_write;
	logic                ovf;
	logic [CNT_W-1:0]    kill_cnt;
	logic [CNT_W-1:0]    count_nxt;

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			core_q <= in_core;
			hop_q  <= in_hop;
		end
	end

	// Per-entry compare lanes
	always_comb begin
		ins_ok = (mode_q == ppft_pkg::MODE_INSERT) && (core_q != '0) && (hop_q != '0);
		for (int i = 0; i < CAPACITY; i++) begin
			kill_c[i]  = valid_q[i] & ins_ok &
				(((tab_core_q[i] <= core_q) && (tab_hop_q[i] < hop_q)) ||
				 ((tab_core_q[i] < core_q) && (tab_hop_q[i] <= hop_q)));
			match_c[i] = valid_q[i] && (tab_core_q[i] == core_q) && (tab_hop_q[i] == hop_q);
			cover_c[i] = valid_q[i] && (tab_core_q[i] >= core_q) && (tab_hop_q[i] >= hop_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			kill_s1    <= kill_c;
			present_s1 <= |match_c;
			cover_s1   <= |cover_c;
			ins_s1     <= ins_ok;
			query_s1   <= (mode_q == ppft_pkg::MODE_QUERY);
		end
	end

	// Survivors, lowest free entry and new count
	always_comb begin
		nv       = valid_q & ~kill_s1;
		full     = &nv;
		free_oh  = ~nv & (nv + 1'b1);
		do_write = ins_s1 & ~present_s1 & ~full;
		ovf      = ins_s1 & ~present_s1 & full;
		kill_cnt = '0;
		for (int i = 0; i < CAPACITY; i++)
			kill_cnt = kill_cnt + CNT_W'(kill_s1[i]);
		count_nxt = count_q - kill_cnt + CNT_W'(do_write);
	end

	// Table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			valid_q <= nv | (do_write ? free_oh : '0);
			count_q <= count_nxt;
		end
	end

	// Entry payload write
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.commit && do_write && free_oh[i]) begin
				tab_core_q[i] <= core_q;
				tab_hop_q[i]  <= hop_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_covered  <= query_s1 & cover_s1;
			res_overflow <= ovf;
			res_count    <= ppft_pkg::COUNT_W'(count_nxt);
		end
	end

`ifndef ASSERT_OFF
	// Running count tracks the valid bits
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count out of step with valid bits");

	// At most one entry is chosen for the write
	a_free_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(free_oh))
		else $error("more than one free entry selected");

	// An overflow only ever leaves the table full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && ovf) |=> (&valid_q))
		else $error("overflow with free entries left");
`endif

endmodule

`default_nettype wire

@@ tb/sv/pareto_pair_frontier_table_top_test.sv @@
`timescale 1ns / 100ps

module pareto_pair_frontier_table_top_test;

	localparam int DEPTH = ppft_pkg::CAPACITY_DEF;
	localparam logic [ppft_pkg::CORE_W-1:0] CORE_MAX = '1;
	localparam logic [ppft_pkg::HOP_W-1:0]  HOP_MAX  = '1;

	// One insert or query beat
	typedef struct packed {
		logic                        mode;
		logic [ppft_pkg::CORE_W-1:0] core;
		logic [ppft_pkg::HOP_W-1:0]  hop;
	} pair_op_t;

	// One result beat
	typedef struct packed {
		logic                         covered;
		logic                         overflow;
		logic [ppft_pkg::COUNT_W-1:0] count;
	} pair_reply_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [ppft_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [ppft_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	pareto_pair_frontier_table_top #(
		.CAPACITY(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the frontier table
	logic                        frontier_valid [DEPTH];
	logic [ppft_pkg::CORE_W-1:0] frontier_core [DEPTH];
	logic [ppft_pkg::HOP_W-1:0]  frontier_hop [DEPTH];

	pair_op_t    pair_ops[$];
	pair_reply_t reply_q[$];

	int ops_total = -1;
	int ops_taken = 0;
	int rand_ops = 0;
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_seg = 0;
	int hold_left = 0;
	int replies_seen = 0;

	// Apply one beat to the shadow table and work out its result
	function automatic pair_reply_t frontier_apply(pair_op_t op);
		pair_reply_t r;
		bit present;
		int slot;
		int n;
		r = '0;
		present = 0;
		slot = -1;
		n = 0;
		if (op.mode == ppft_pkg::MODE_INSERT) begin
			if (op.core != '0 && op.hop != '0) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (frontier_valid[i]) begin
						if ((frontier_core[i] <= op.core && frontier_hop[i] < op.hop) ||
						    (frontier_core[i] < op.core && frontier_hop[i] <= op.hop))
							frontier_valid[i] = 1'b0;
						else if (frontier_core[i] == op.core && frontier_hop[i] == op.hop)
							present = 1;
					end
				end
				if (!present) begin
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!frontier_valid[i])
							slot = i;
					if (slot < 0) begin
						r.overflow = 1'b1;
					end else begin
						frontier_valid[slot] = 1'b1;
						frontier_core[slot]  = op.core;
						frontier_hop[slot]   = op.hop;
					end
				end
			end
		end else begin
			for (int i = 0; i < DEPTH; i++)
				if (frontier_valid[i] && frontier_core[i] >= op.core &&
				    frontier_hop[i] >= op.hop)
					r.covered = 1'b1;
		end
		for (int i = 0; i < DEPTH; i++)
			if (frontier_valid[i])
				n++;
		r.count = n[ppft_pkg::COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_op(input logic mode, input logic [ppft_pkg::CORE_W-1:0] core,
	                      input logic [ppft_pkg::HOP_W-1:0] hop);
		pair_op_t op;
		op.mode = mode;
		op.core = core;
		op.hop  = hop;
		pair_ops.push_back(op);
		if (!(mode == ppft_pkg::MODE_INSERT && (core == '0 || hop == '0)))
			rand_ops++;
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		errors++;
	endtask

	// Clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: bursts with random gaps, beat held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				reply_q.push_back(frontier_apply(pair_ops[0]));
				pair_ops.pop_front();
				ops_taken++;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pair_ops.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {{(ppft_pkg::IN_TDATA_W - ppft_pkg::CORE_W -
				                    ppft_pkg::HOP_W){1'b0}},
				                  pair_ops[0].hop, pair_ops[0].core};
				s_axis_tuser  <= pair_ops[0].mode;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(15, 25);
						default: gap_left = $urandom_range(1, 5);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern changes by segment, with long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				replies_seen++;
				if (replies_seen == 150 || replies_seen == 500)
					hold_left = 300;
			end
			if (stall_seg <= 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_seg  = $urandom_range(20, 120);
			end else begin
				stall_seg--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	// Monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_reply
		pair_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_q.size() == 0) begin
				flag_mismatch("unexpected result beat", m_axis_tdata, -1);
			end else begin
				want = reply_q.pop_front();
				if (m_axis_tdata[0] !== want.covered)
					flag_mismatch("covered", m_axis_tdata[0], want.covered);
				if (m_axis_tdata[1] !== want.overflow)
					flag_mismatch("overflow", m_axis_tdata[1], want.overflow);
				if (m_axis_tdata[6:2] !== want.count)
					flag_mismatch("entry_count", m_axis_tdata[6:2], want.count);
				if (m_axis_tdata[7] !== 1'b0)
					flag_mismatch("tdata padding", m_axis_tdata[7], 0);
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int c0, h0, cs, hs, n, kind;
		for (int i = 0; i < DEPTH; i++) begin
			frontier_valid[i] = 1'b0;
			frontier_core[i]  = '0;
			frontier_hop[i]   = '0;
		end

		// Directed: empty table, zero inserts, identical pair, dominated insert
		add_op(ppft_pkg::MODE_QUERY, '0, '0);
		add_op(ppft_pkg::MODE_QUERY, CORE_MAX, HOP_MAX);
		add_op(ppft_pkg::MODE_INSERT, '0, 8'd5);
		add_op(ppft_pkg::MODE_INSERT, 20'd7, '0);
		add_op(ppft_pkg::MODE_INSERT, CORE_MAX, HOP_MAX);
		add_op(ppft_pkg::MODE_QUERY, '0, '0);
		add_op(ppft_pkg::MODE_QUERY, CORE_MAX, HOP_MAX);
		add_op(ppft_pkg::MODE_INSERT, CORE_MAX, HOP_MAX);
		add_op(ppft_pkg::MODE_INSERT, 20'd1, 8'd1);
		add_op(ppft_pkg::MODE_INSERT, 20'd1, 8'd2);
		// Fill to capacity with incomparable pairs, then overflow
		for (int i = 0; i < DEPTH - 1; i++)
			add_op(ppft_pkg::MODE_INSERT, 20'(10 + i), 8'(100 - i));
		add_op(ppft_pkg::MODE_INSERT, 20'd30, 8'd50);
		// Identical pair in a full table, then removal frees room in a full table
		add_op(ppft_pkg::MODE_INSERT, 20'(10 + DEPTH - 2), 8'(100 - DEPTH + 2));
		add_op(ppft_pkg::MODE_INSERT, 20'(10 + DEPTH - 2), 8'(101 - DEPTH + 2));
		rand_ops = 0;

		// Random phases
		while (rand_ops < 700) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				// run of incomparable pairs, sometimes enough to fill the table
				n  = $urandom_range(10, 20);
				cs = $urandom_range(1, 50);
				hs = $urandom_range(1, 12);
				c0 = $urandom_range(1, 1000);
				h0 = $urandom_range(n * hs + 1, 255);
				for (int i = 0; i < n; i++)
					add_op(ppft_pkg::MODE_INSERT, 20'(c0 + i * cs), 8'(h0 - i * hs));
				if ($urandom_range(0, 1))
					add_op(ppft_pkg::MODE_INSERT, 20'(c0), 8'(h0));
				for (int i = 0; i < 4; i++)
					add_op(ppft_pkg::MODE_QUERY, 20'(c0 + $urandom_range(0, n * cs)),
					       8'(h0 - $urandom_range(0, n * hs)));
			end else if (kind < 7) begin
				// small values: frequent dominance and identical pairs
				for (int i = 0; i < 20; i++)
					add_op(1'($urandom_range(0, 1)), 20'($urandom_range(0, 7)),
					       8'($urandom_range(0, 7)));
			end else if (kind < 9) begin
				// full-range values
				for (int i = 0; i < 10; i++)
					add_op(1'($urandom_range(0, 1)), 20'($urandom), 8'($urandom));
			end else begin
				// clear down to one entry via the largest pair
				add_op(ppft_pkg::MODE_INSERT, CORE_MAX, HOP_MAX);
				add_op(ppft_pkg::MODE_QUERY, '0, '0);
				add_op(ppft_pkg::MODE_QUERY, CORE_MAX, HOP_MAX);
				add_op(ppft_pkg::MODE_INSERT, '0, 8'($urandom_range(1, 255)));
				add_op(ppft_pkg::MODE_INSERT, 20'($urandom_range(1, 1048575)), '0);
			end
		end
		ops_total = ops_taken + pair_ops.size();

		while (ops_taken != ops_total)
			@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[pareto_pair_frontier_table_top] OK");
		else
			$display("[pareto_pair_frontier_table_top] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("[pareto_pair_frontier_table_top] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ppft_pkg.sv
hdl/ppft_ctrl.sv
hdl/ppft_dp.sv
hdl/pareto_pair_frontier_table_top.sv
tb/sv/pareto_pair_frontier_table_top_test.sv
